// ----- design/vhpd_pkg.sv -----
// Package for the hashed voxel downsampler: widths, register codes, hash
// coefficients and the item, slot and divider status types.
// No dependencies.
package vhpd_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam int PT_W    = 24;
   localparam int INV_W   = 24;
   localparam int MIN_W   = 16;
   localparam int CNT_W   = 16;
   localparam int COORD_W = 21;
   localparam int SUM_W   = 40;
   localparam int PROD_W  = PT_W + INV_W + 1;
   localparam int FRAC_W  = 28;
   localparam int DRN_W   = 10;
   localparam int STEP_W  = $clog2(SUM_W);

   localparam logic [31:0] HASH_CX = 32'd7171;
   localparam logic [31:0] HASH_CY = 32'd3079;
   localparam logic [31:0] HASH_CZ = 32'd4231;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_VOXEL_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OCCUPANTS  = 2'd1;
   localparam logic [INV_W-1:0] INV_RESET = 24'd501760;
   localparam logic [MIN_W-1:0] MIN_RESET = 16'd8;

   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_DRAIN   = 1'b1;
   localparam logic CAUSE_EVICT = 1'b0;
   localparam logic CAUSE_DRAIN = 1'b1;

   typedef struct packed {
      logic                    action;
      logic signed [PT_W-1:0]  point_x;
      logic signed [PT_W-1:0]  point_y;
      logic signed [PT_W-1:0]  point_z;
      logic [DRN_W-1:0]        drain_index;
   } req_item_type;

   typedef struct packed {
      logic signed [PT_W-1:0] mean_x;
      logic signed [PT_W-1:0] mean_y;
      logic signed [PT_W-1:0] mean_z;
      logic                   emit_cause;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic signed [SUM_W-1:0]   sum_x;
      logic signed [SUM_W-1:0]   sum_y;
      logic signed [SUM_W-1:0]   sum_z;
      logic [CNT_W-1:0]          count;
   } slot_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- design/voxel_hash_point_downsampler.sv -----
// Top level of the hashed voxel-grid point downsampler: control sequencer,
// voxel mapping and hash. Uses vhpd_pkg, vhpd_slot_ram, vhpd_divider.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_item_type
//   rsp     | out       | rsp_valid/rsp_stall | rsp_item_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An item that emits nothing goes through accept, multiply, hash and RAM
// read, and update/write-back, the steps of the slot RAM read-modify-write.
// An emitting item then runs the 40-step divider and a finish step that
// loads the output register. After reset a clearing pass zeroes all 1024 slot
// counts, one slot per cycle; req_stall stays high throughout the pass.
// A result waiting in the output register does not block the next item; only
// a second result waits for it.
module voxel_hash_point_downsampler
   import vhpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INV_W-1:0]     csr_data
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_HASH  = 3'd3;
   localparam logic [2:0] ST_DEC   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff;
   logic [INV_W-1:0] inv_ff;
   logic [MIN_W-1:0] min_ff;
   req_item_type     req_ff;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [COORD_W-1:0] coord_x_ff, coord_y_ff, coord_z_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             cause_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;

   logic signed [INV_W:0]     inv_s;
   logic signed [COORD_W-1:0] cx, cy, cz;
   logic [31:0]      hash;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   slot_entry_type   old_entry, new_entry;
   logic [$bits(slot_entry_type)-1:0] rd_raw;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             occupied, same, evict, emit;
   logic             div_start;
   div_status_type   div_status;
   logic signed [PT_W-1:0] q_x, q_y, q_z;
   logic             out_free, req_take;

   // ---- configuration: always ready; the user must write only while idle, not enforced
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= INV_RESET;
         min_ff <= MIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INV_VOXEL_SIZE: inv_ff <= csr_data;
            CSR_MIN_OCCUPANTS:  min_ff <= csr_data[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- voxel mapping: product in Q.28, floor is the arithmetic top slice
   assign inv_s = {1'b0, inv_ff};
   assign cx = prod_x_ff[PROD_W-1:FRAC_W];
   assign cy = prod_y_ff[PROD_W-1:FRAC_W];
   assign cz = prod_z_ff[PROD_W-1:FRAC_W];

   // only the low index bits of the 32-bit hash survive the mask
   assign hash = 32'(signed'(cx)) * HASH_CX + 32'(signed'(cy)) * HASH_CY
               + 32'(signed'(cz)) * HASH_CZ;
   assign rd_addr = (req_ff.action == ACT_DRAIN) ? IDX_W'(req_ff.drain_index)
                                                 : hash[IDX_W-1:0];
   assign rd_en = (state_ff == ST_HASH);

   // ---- update decision on the slot just read
   assign old_entry = slot_entry_type'(rd_raw);
   assign occupied  = old_entry.count != '0;
   assign same      = (old_entry.coord_x == coord_x_ff)
                   && (old_entry.coord_y == coord_y_ff)
                   && (old_entry.coord_z == coord_z_ff);

   always_comb begin
      new_entry = old_entry;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      evict     = 1'b0;
      if (state_ff == ST_CLEAR) begin
         wr_en     = 1'b1;
         wr_addr   = clr_ff;
         new_entry = '0;
      end else if (state_ff == ST_DEC) begin
         if (req_ff.action == ACT_DRAIN) begin
            evict           = occupied;
            wr_en           = 1'b1;
            new_entry.count = '0;
         end else if (!occupied || !same) begin
            evict     = occupied;
            wr_en     = 1'b1;
            new_entry.coord_x = coord_x_ff;
            new_entry.coord_y = coord_y_ff;
            new_entry.coord_z = coord_z_ff;
            new_entry.sum_x   = SUM_W'(req_ff.point_x);
            new_entry.sum_y   = SUM_W'(req_ff.point_y);
            new_entry.sum_z   = SUM_W'(req_ff.point_z);
            new_entry.count   = CNT_W'(1);
         end else if (old_entry.count != COUNT_MAX) begin
            // same voxel, not yet full: accumulate
            wr_en = 1'b1;
            new_entry.sum_x = old_entry.sum_x + SUM_W'(req_ff.point_x);
            new_entry.sum_y = old_entry.sum_y + SUM_W'(req_ff.point_y);
            new_entry.sum_z = old_entry.sum_z + SUM_W'(req_ff.point_z);
            new_entry.count = old_entry.count + 1'b1;
         end
      end
   end

   assign emit      = evict && (old_entry.count > min_ff);
   assign div_start = (state_ff == ST_DEC) && emit;

   vhpd_slot_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (new_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // old sums go to the divider the same cycle the slot is overwritten
   vhpd_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sum_x  (old_entry.sum_x),
      .sum_y  (old_entry.sum_y),
      .sum_z  (old_entry.sum_z),
      .count  (old_entry.count),
      .status (div_status),
      .q_x    (q_x),
      .q_y    (q_y),
      .q_z    (q_z)
   );

   // ---- sequencer
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_HASH;
         ST_HASH:  state_in = ST_DEC;
         ST_DEC:   state_in = emit ? ST_DIV : ST_IDLE;
         ST_DIV:   if (div_status.done) state_in = ST_FIN;
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_item;
      end
      if (state_ff == ST_MUL) begin
         prod_x_ff <= req_ff.point_x * inv_s;
         prod_y_ff <= req_ff.point_y * inv_s;
         prod_z_ff <= req_ff.point_z * inv_s;
      end
      if (state_ff == ST_HASH) begin
         coord_x_ff <= cx;
         coord_y_ff <= cy;
         coord_z_ff <= cz;
         idx_ff     <= rd_addr;
      end
      if (div_start) begin
         cause_ff <= (req_ff.action == ACT_DRAIN) ? CAUSE_DRAIN : CAUSE_EVICT;
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_item_ff.mean_x     <= q_x;
         rsp_item_ff.mean_y     <= q_y;
         rsp_item_ff.mean_z     <= q_z;
         rsp_item_ff.emit_cause <= cause_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTH
   a_take_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_MUL)
      else $error("accepted item did not enter multiply");
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_DEC || state_ff == ST_CLEAR))
      else $error("slot write outside update or clear");
   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish state");
`endif

endmodule

// ----- design/vhpd_slot_ram.sv -----
// Single-port-write, single-port-read synchronous RAM holding the voxel slots.
// Read data registered. No dependencies.
module vhpd_slot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/vhpd_divider.sv -----
// Three-lane restoring divider: signed 40-bit sums over an unsigned count,
// one quotient bit per cycle, truncating toward zero. Uses vhpd_pkg.
module vhpd_divider
   import vhpd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] sum_x,
   input  logic signed [SUM_W-1:0] sum_y,
   input  logic signed [SUM_W-1:0] sum_z,
   input  logic [CNT_W-1:0]        count,
   output div_status_type          status,
   output logic signed [PT_W-1:0]  q_x,
   output logic signed [PT_W-1:0]  q_y,
   output logic signed [PT_W-1:0]  q_z
);

   logic [SUM_W-1:0]  work_ff [3];
   logic [CNT_W-1:0]  rem_ff  [3];
   logic              neg_ff  [3];
   logic [CNT_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic signed [SUM_W-1:0] sum_in [3];
   logic [CNT_W:0]          shifted [3];
   logic                    fits [3];
   logic [SUM_W-1:0]        quot [3];

   assign sum_in[0] = sum_x;
   assign sum_in[1] = sum_y;
   assign sum_in[2] = sum_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i] = {rem_ff[i], work_ff[i][SUM_W-1]};
         fits[i]    = shifted[i] >= {1'b0, den_ff};
         quot[i]    = neg_ff[i] ? (~work_ff[i] + 1'b1) : work_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= count;
         for (int i = 0; i < 3; i++) begin
            neg_ff[i]  <= sum_in[i][SUM_W-1];
            work_ff[i] <= sum_in[i][SUM_W-1] ? (~sum_in[i] + 1'b1) : sum_in[i];
            rem_ff[i]  <= '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[i]  <= fits[i] ? CNT_W'(shifted[i] - {1'b0, den_ff})
                                  : shifted[i][CNT_W-1:0];
            work_ff[i] <= {work_ff[i][SUM_W-2:0], fits[i]};
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign q_x = quot[0][PT_W-1:0];
   assign q_y = quot[1][PT_W-1:0];
   assign q_z = quot[2][PT_W-1:0];

endmodule

// ----- test/vhpd_tb_pkg.sv -----
// Shared helpers for the downsampler testbench: voxel mapping and slot hash.
// Used by the checker and by the stimulus side to aim drains at live slots.
// Depends on vhpd_pkg.
package vhpd_tb_pkg;
   import vhpd_pkg::*;

   // floor(p * inv / 2^28); the arithmetic shift rounds toward minus infinity
   function automatic int floor_voxel(logic signed [PT_W-1:0] p, logic [INV_W-1:0] inv);
      longint prod;
      prod = longint'(p) * longint'({1'b0, inv});
      return int'(prod >>> FRAC_W);
   endfunction

   function automatic logic [IDX_W-1:0] hash_slot(int cx, int cy, int cz);
      logic [31:0] h;
      h = 32'(cx) * HASH_CX + 32'(cy) * HASH_CY + 32'(cz) * HASH_CZ;
      return h[IDX_W-1:0];
   endfunction

endpackage

// ----- test/vhpd_checker.sv -----
// Checker for the downsampler: watches the csr, req and rsp channels, keeps
// its own copy of the voxel table and compares every result item in order.
// Depends on vhpd_pkg and vhpd_tb_pkg.
module vhpd_checker
   import vhpd_pkg::*;
   import vhpd_tb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_item_type         req_item,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INV_W-1:0]     csr_data,
   output int                   error_count,
   output int                   means_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   int     voxel_xyz [TABLE_ENTRIES][3];
   longint sum_x [TABLE_ENTRIES];
   longint sum_y [TABLE_ENTRIES];
   longint sum_z [TABLE_ENTRIES];
   int     occupants [TABLE_ENTRIES];
   logic [INV_W-1:0] inv_size;
   logic [MIN_W-1:0] min_occ;
   rsp_item_type expected_means [$];

   task automatic flush_voxel(int s, logic cause);
      rsp_item_type m;
      if (occupants[s] != 0 && occupants[s] > int'(min_occ)) begin
         m.mean_x     = PT_W'(sum_x[s] / longint'(occupants[s]));
         m.mean_y     = PT_W'(sum_y[s] / longint'(occupants[s]));
         m.mean_z     = PT_W'(sum_z[s] / longint'(occupants[s]));
         m.emit_cause = cause;
         expected_means = {expected_means, m};
      end
   endtask

   task automatic absorb_item(req_item_type it);
      int cx, cy, cz, s;
      if (it.action == ACT_DRAIN) begin
         s = int'(it.drain_index) & (TABLE_ENTRIES - 1);
         flush_voxel(s, CAUSE_DRAIN);
         occupants[s] = 0;
      end else begin
         cx = floor_voxel(it.point_x, inv_size);
         cy = floor_voxel(it.point_y, inv_size);
         cz = floor_voxel(it.point_z, inv_size);
         s  = int'(hash_slot(cx, cy, cz));
         if (occupants[s] != 0 && (voxel_xyz[s][0] != cx || voxel_xyz[s][1] != cy ||
                                   voxel_xyz[s][2] != cz)) begin
            flush_voxel(s, CAUSE_EVICT);
            occupants[s] = 0;
         end
         if (occupants[s] == 0) begin
            voxel_xyz[s][0] = cx;
            voxel_xyz[s][1] = cy;
            voxel_xyz[s][2] = cz;
            sum_x[s] = longint'(it.point_x);
            sum_y[s] = longint'(it.point_y);
            sum_z[s] = longint'(it.point_z);
            occupants[s] = 1;
         end else if (occupants[s] < int'(COUNT_MAX)) begin
            sum_x[s] += longint'(it.point_x);
            sum_y[s] += longint'(it.point_y);
            sum_z[s] += longint'(it.point_z);
            occupants[s]++;
         end
      end
   endtask

   task automatic compare_mean(rsp_item_type got);
      rsp_item_type want;
      if (expected_means.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%t: unexpected result item %h", $realtime, got);
      end else begin
         want = expected_means.pop_front();
         if (got.mean_x !== want.mean_x || got.mean_y !== want.mean_y ||
             got.mean_z !== want.mean_z || got.emit_cause !== want.emit_cause) begin
            error_count++;
            if (error_count <= 10)
               $display("%t: mismatch x %h/%h y %h/%h z %h/%h cause %b/%b (exp/got)",
                        $realtime, want.mean_x, got.mean_x, want.mean_y, got.mean_y,
                        want.mean_z, got.mean_z, want.emit_cause, got.emit_cause);
         end
      end
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) occupants[i] = 0;
         inv_size = INV_RESET;
         min_occ  = MIN_RESET;
         expected_means.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_INV_VOXEL_SIZE) inv_size = csr_data;
            else if (csr_index == CSR_MIN_OCCUPANTS) min_occ = csr_data[MIN_W-1:0];
         end
         if (rsp_valid && !rsp_stall) compare_mean(rsp_item);
         if (req_valid && !req_stall) absorb_item(req_item);
      end
      means_pending = expected_means.size();
   end

endmodule

// ----- test/tb_voxel_hash_point_downsampler.sv -----
// Testbench top for the hashed voxel downsampler: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on vhpd_pkg, vhpd_tb_pkg,
// vhpd_checker and the block itself.
module tb_voxel_hash_point_downsampler;
   import vhpd_pkg::*;
   import vhpd_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // no item moving for this many cycles means the block is hung;
   // covers the clearing pass, a divide and long stalls
   localparam int HANG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 80;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_item_type         req_item;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_item_type         rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [INV_W-1:0]     csr_data;
   int                   error_count;
   int                   means_pending;

   voxel_hash_point_downsampler dut (.*);

   vhpd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: counts cycles with no handshake on any channel
   int hang_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         hang_cycles <= 0;
      end else begin
         hang_cycles <= hang_cycles + 1;
         if (hang_cycles >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver: windows of random length, each free-flowing, light or heavy stall
   int stall_window;
   int stall_pct;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_window <= 0;
         stall_pct    <= 0;
      end else if (stall_window == 0) begin
         stall_window <= $urandom_range(20, 200);
         case ($urandom_range(2))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            default: stall_pct <= 75;
         endcase
         rsp_stall <= 1'b0;
      end else begin
         stall_window <= stall_window - 1;
         rsp_stall    <= ($urandom_range(99) < stall_pct);
      end
   end

   // sender state
   logic [INV_W-1:0] cur_inv;
   int               burst_left;
   bit               no_gaps;
   logic [IDX_W-1:0] last_slot;

   // drive one item and hold it until taken; valid stays up inside a burst
   task automatic send_item(logic act, int x, int y, int z, int idx);
      req_item_type it;
      it.action      = act;
      it.point_x     = PT_W'(x);
      it.point_y     = PT_W'(y);
      it.point_z     = PT_W'(z);
      it.drain_index = DRN_W'(idx);
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      if (!no_gaps) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
   endtask

   task automatic insert_point(int x, int y, int z);
      send_item(ACT_INSERT, x, y, z, $urandom_range(1023));
      last_slot = hash_slot(floor_voxel(PT_W'(x), cur_inv), floor_voxel(PT_W'(y), cur_inv),
                            floor_voxel(PT_W'(z), cur_inv));
   endtask

   task automatic drain_slot(int idx);
      send_item(ACT_DRAIN, $urandom, $urandom, $urandom, idx);
   endtask

   // lets every result land, then the item pipeline empty, before a csr write;
   // waits on the clock first so the checker has taken the last item
   task automatic settle();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (means_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers written back to back; valid stays high across the pair
   task automatic set_config(logic [INV_W-1:0] inv, logic [MIN_W-1:0] min_occ);
      csr_valid <= 1'b1;
      csr_index <= CSR_INV_VOXEL_SIZE;
      csr_data  <= inv;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MIN_OCCUPANTS;
      csr_data  <= INV_W'(min_occ);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      cur_inv = inv;
   endtask

   // mostly clusters of nearby points, mixed with noise and drains
   task automatic random_mix(int n_items);
      int sent, cx, cy, cz, len, pick;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            cx  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            cy  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            cz  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            len = $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
               insert_point(cx + int'($urandom_range(400)), cy + int'($urandom_range(400)),
                            cz + int'($urandom_range(400)));
            sent += len;
         end else if (pick < 80) begin
            insert_point($urandom, $urandom, $urandom);
            sent++;
         end else if (pick < 92) begin
            drain_slot(last_slot);
            sent++;
         end else begin
            drain_slot($urandom_range(1023));
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_INV_VOXEL_SIZE;
      csr_data   = '0;
      cur_inv    = INV_RESET;
      burst_left = 8;
      no_gaps    = 1'b0;
      last_slot  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: extreme points, empty drain, drain at the
      // top index, point fields ignored on a drain
      drain_slot(5);
      for (int k = 0; k < 10; k++) insert_point(8388607, 8388607, 8388607);
      drain_slot(last_slot);
      for (int k = 0; k < 9; k++) insert_point(-8388608, -8388608, -8388608);
      drain_slot(last_slot);
      for (int k = 0; k < 3; k++) insert_point(-1, 0, 1);
      drain_slot(last_slot);   // too few points: no result
      drain_slot(1023);
      random_mix(300);
      settle();

      // zero reciprocal, every point lands in the origin voxel
      set_config('0, '0);
      no_gaps = 1'b1;
      for (int k = 0; k < 40; k++) insert_point($urandom, $urandom, $urandom);
      drain_slot(0);
      no_gaps = 1'b0;
      burst_left = 1;
      insert_point(-8388608, 8388607, 0);
      drain_slot(0);   // one point with threshold zero still emits
      settle();

      // finest voxels, everything emits: evictions everywhere
      set_config(24'hFFFFFF, '0);
      random_mix(300);
      settle();

      // coarsest nonzero reciprocal, nothing may ever emit
      set_config(24'd1, 16'hFFFF);
      random_mix(200);
      settle();

      set_config(INV_W'($urandom_range(1, 24'hFFFFFF)), MIN_W'($urandom_range(0, 4)));
      random_mix(300);
      settle();

      set_config(INV_W'($urandom_range(100000, 2000000)), MIN_W'($urandom_range(0, 3)));
      random_mix(300);
      settle();

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
